// ===== src/adx_pkg.sv =====
// Shared types and constants for the ADX threshold trader.
`default_nettype none
package adx_pkg;

  // Shared divider operand widths
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = 6;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 23;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // 100 percent in Q16.16
  localparam logic [22:0] PCT_FULL = 23'd6553600;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_LIMIT  = 2'd1,
    REG_THRESH = 2'd2
  } cfg_reg_t;

  // Order codes
  typedef enum logic [1:0] {
    ORD_NONE = 2'd0,
    ORD_BUY  = 2'd1,
    ORD_SELL = 2'd2
  } order_t;

endpackage
`default_nettype wire

// ===== src/adx_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module adx_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [adx_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [adx_pkg::DIV_DEN_W-1:0] den,
  output logic                               done,
  output logic [adx_pkg::DIV_NUM_W-1:0]      quot
);
  import adx_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_NUM_W-1:0] nq;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // Trial subtraction for the current bit
  assign trial = {rem, nq[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quot  = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        nq   <= num;
        dvs  <= den;
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_DEN_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[DIV_DEN_W-1:0];
        end
        nq  <= {nq[DIV_NUM_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/adx_mul.sv =====
// Shared unsigned multiplier with registered product.
`default_nettype none
module adx_mul (
  input  wire logic                        clk,
  input  wire logic [adx_pkg::MUL_A_W-1:0] a,
  input  wire logic [adx_pkg::MUL_B_W-1:0] b,
  output logic [adx_pkg::MUL_P_W-1:0]      p
);
  import adx_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end
endmodule
`default_nettype wire

// ===== src/adx_threshold_trader_unit.sv =====
// ADX threshold trader: sequencer around a shared divider and multiplier.
//
// Input channel: one price bar (high, low, close, final flag) per transaction,
// accepted when in_valid is high and in_stall is low. in_stall is high while
// a bar is being worked on, so one bar is processed at a time.
// Output channel: one result per bar, held in an output register until the
// receiver takes it (out_valid high, out_stall low). A new bar can be
// accepted while that result is still waiting; the block only waits at the
// end of the next bar if the output register is still full.
// Configuration: cfg_valid/cfg_ready write channel, always ready. Writing the
// period marks alpha stale; it is recomputed with the divider at the start of
// the next bar.
// Per bar: a priming bar goes straight to the output step, and a final bar
// adds a step for the square-off product. Each division runs on the shared
// 56-step divider (a zero divisor skips it and gives zero): a normal bar needs
// three divisions, the seeding bar six. The next bar can be accepted in the
// cycle after the result is registered.
// Reset clears all trading state and loads the register defaults (period 14,
// limit 1, threshold 25 percent). After a final bar the trading state clears
// itself so the next bar primes a new run.
`default_nettype none
module adx_threshold_trader_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  // input bars
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        high_price,
  input  wire logic [31:0]        low_price,
  input  wire logic [31:0]        close_price,
  input  wire logic               final_bar,
  // results
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              order_code,
  output logic signed [16:0]      position_now,
  output logic signed [47:0]      cash_now,
  output logic [22:0]             adx_now,
  output logic signed [47:0]      square_off_pnl,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [22:0]        cfg_data
);
  import adx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_ALPHA,
    S_SEED_P, S_SEED_M, S_SEED_DXM, S_SEED_DXD,
    S_ATR_M, S_ATR_U, S_RP_D, S_DIP_M, S_DIP_U,
    S_RM_D, S_DIM_M, S_DIM_U, S_DX_M, S_DX_D,
    S_ADX_M, S_ADX_U, S_TRADE, S_PNL_M, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [10:0] period;
  logic [15:0] limit;
  logic [22:0] thresh;
  logic [16:0] alpha;
  logic        alpha_stale;

  // captured bar
  logic [31:0] h, l, c;
  logic        fin;

  // trading state
  logic [31:0]        prev_high, prev_low, prev_close;
  logic [31:0]        atr, dip, dim, tmp;
  logic [22:0]        adx;
  logic signed [16:0] pos;
  logic signed [47:0] cash;
  logic [1:0]         phase;
  order_t             order_r;

  // shared units
  logic                 div_go;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_q;
  logic                 is_div;
  logic                 div_zero;
  logic                 div_fin;
  logic [DIV_NUM_W-1:0] div_val;
  logic [31:0]          ratio;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   prod;

  // per-bar values
  logic [31:0] tr_seed, tr_prev, dmp, dmm;
  logic [31:0] ema_old, ema_new, ema_res, step;
  logic [10:0] n_eff;
  logic [11:0] n_p1;
  logic signed [16:0] lim_s;
  logic [15:0]        pos_mag;
  logic signed [49:0] buy_sum, sell_sum, pnl_sum, pmag;
  logic signed [47:0] pnl_val;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [31:0] true_range(input logic [31:0] hh, input logic [31:0] ll,
                                             input logic [31:0] rc);
    logic [31:0] t1, t2, t;
    t1 = abs_diff(hh, rc);
    t2 = abs_diff(ll, rc);
    t  = (t2 > t1) ? t2 : t1;
    if (hh > ll && (hh - ll) > t) begin
      t = hh - ll;
    end
    true_range = t;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      sat48 = 48'sh7FFF_FFFF_FFFF;
    end else if (v < -50'sh0_8000_0000_0000) begin
      sat48 = 48'sh8000_0000_0000;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

  // bar measurements
  assign tr_seed = true_range(h, l, c);
  assign tr_prev = true_range(h, l, prev_close);
  assign dmp     = (h > prev_high) ? h - prev_high : '0;
  assign dmm     = (prev_low > l) ? prev_low - l : '0;
  assign n_eff   = (period == '0) ? 11'd1 : period;
  assign n_p1    = {1'b0, n_eff} + 12'd1;

  // divider operand selection
  always_comb begin
    is_div  = 1'b1;
    div_num = '0;
    div_den = '0;
    unique case (state)
      S_ALPHA: begin
        div_num = DIV_NUM_W'(18'd131072 + 18'(n_p1 >> 1));
        div_den = DIV_DEN_W'(n_p1);
      end
      S_SEED_P, S_RP_D: begin
        div_num = DIV_NUM_W'({dmp, 16'h0});
        div_den = DIV_DEN_W'(atr);
      end
      S_SEED_M, S_RM_D: begin
        div_num = DIV_NUM_W'({dmm, 16'h0});
        div_den = DIV_DEN_W'(atr);
      end
      S_SEED_DXD, S_DX_D: begin
        div_num = DIV_NUM_W'(prod);
        div_den = DIV_DEN_W'(dip) + DIV_DEN_W'(dim);
      end
      default: is_div = 1'b0;
    endcase
  end

  assign div_zero  = div_den == '0;
  assign div_start = is_div && !div_zero && !div_go;
  assign div_fin   = is_div && (div_zero || div_done);
  assign div_val   = div_zero ? '0 : div_q;
  assign ratio     = (div_val[DIV_NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : div_val[31:0];

  // smoothing operands
  always_comb begin
    ema_old = '0;
    ema_new = '0;
    unique case (state)
      S_ATR_M, S_ATR_U: begin
        ema_old = atr;
        ema_new = tr_prev;
      end
      S_DIP_M, S_DIP_U: begin
        ema_old = dip;
        ema_new = tmp;
      end
      S_DIM_M, S_DIM_U: begin
        ema_old = dim;
        ema_new = tmp;
      end
      S_ADX_M, S_ADX_U: begin
        ema_old = 32'(adx);
        ema_new = tmp;
      end
      default: begin
        ema_old = '0;
        ema_new = '0;
      end
    endcase
  end

  assign pos_mag = pos[16] ? 16'(-pos) : pos[15:0];

  // multiplier operand selection; the square-off product is held while the
  // output step waits
  always_comb begin
    unique case (state)
      S_SEED_DXM, S_DX_M: begin
        mul_a = abs_diff(dip, dim);
        mul_b = PCT_FULL;
      end
      S_PNL_M, S_OUT: begin
        mul_a = c;
        mul_b = MUL_B_W'(pos_mag);
      end
      default: begin
        mul_a = abs_diff(ema_old, ema_new);
        mul_b = MUL_B_W'(alpha);
      end
    endcase
  end

  // rounded smoothing step
  assign step    = 32'((prod + MUL_P_W'(32768)) >> 16);
  assign ema_res = (ema_new >= ema_old) ? ema_old + step : ema_old - step;

  // trade and settlement sums
  assign lim_s    = {1'b0, limit};
  assign buy_sum  = 50'(cash) - $signed({18'h0, c});
  assign sell_sum = 50'(cash) + $signed({18'h0, c});
  assign pmag     = $signed({1'b0, prod[48:0]});
  assign pnl_sum  = 50'(cash) + (pos[16] ? -pmag : pmag);
  assign pnl_val  = fin ? sat48(pnl_sum) : '0;

  assign in_stall  = state != S_IDLE;
  assign cfg_ready = 1'b1;

  adx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  adx_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      period      <= 11'd14;
      limit       <= 16'd1;
      thresh      <= 23'd1638400;
      alpha       <= 17'd8738;
      alpha_stale <= 1'b0;
      div_go      <= 1'b0;
      out_valid   <= 1'b0;
      prev_high   <= '0;
      prev_low    <= '0;
      prev_close  <= '0;
      atr         <= '0;
      dip         <= '0;
      dim         <= '0;
      adx         <= '0;
      pos         <= '0;
      cash        <= '0;
      phase       <= '0;
      order_r     <= ORD_NONE;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PERIOD: period <= cfg_data[10:0];
          REG_LIMIT:  limit  <= cfg_data[15:0];
          REG_THRESH: thresh <= cfg_data;
          default: ;
        endcase
      end

      // alpha goes stale on a period write, fresh once recomputed
      if (cfg_valid && cfg_ready && cfg_index == REG_PERIOD) begin
        alpha_stale <= 1'b1;
      end else if (state == S_ALPHA && div_fin) begin
        alpha_stale <= 1'b0;
      end

      // divider handshake
      if (div_start) begin
        div_go <= 1'b1;
      end else if (div_done) begin
        div_go <= 1'b0;
      end

      // result register: loads on the output step, empties when taken
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            h     <= high_price;
            l     <= low_price;
            c     <= close_price;
            fin   <= final_bar;
            state <= S_START;
          end
        end
        S_START: begin
          order_r <= ORD_NONE;
          if (alpha_stale) begin
            state <= S_ALPHA;
          end else if (phase == 2'd0) begin
            state <= fin ? S_PNL_M : S_OUT;
          end else if (phase == 2'd1) begin
            atr   <= tr_seed;
            phase <= 2'd2;
            state <= S_SEED_P;
          end else begin
            state <= S_ATR_M;
          end
        end
        S_ALPHA: begin
          if (div_fin) begin
            alpha <= div_val[16:0];
            state <= S_START;
          end
        end
        S_SEED_P: begin
          if (div_fin) begin
            dip   <= ratio;
            state <= S_SEED_M;
          end
        end
        S_SEED_M: begin
          if (div_fin) begin
            dim   <= ratio;
            state <= S_SEED_DXM;
          end
        end
        S_SEED_DXM: state <= S_SEED_DXD;
        S_SEED_DXD: begin
          if (div_fin) begin
            adx   <= div_val[22:0];
            state <= S_ATR_M;
          end
        end
        S_ATR_M: state <= S_ATR_U;
        S_ATR_U: begin
          atr   <= ema_res;
          state <= S_RP_D;
        end
        S_RP_D: begin
          if (div_fin) begin
            tmp   <= ratio;
            state <= S_DIP_M;
          end
        end
        S_DIP_M: state <= S_DIP_U;
        S_DIP_U: begin
          dip   <= ema_res;
          state <= S_RM_D;
        end
        S_RM_D: begin
          if (div_fin) begin
            tmp   <= ratio;
            state <= S_DIM_M;
          end
        end
        S_DIM_M: state <= S_DIM_U;
        S_DIM_U: begin
          dim   <= ema_res;
          state <= S_DX_M;
        end
        S_DX_M: state <= S_DX_D;
        S_DX_D: begin
          if (div_fin) begin
            tmp   <= 32'(div_val[22:0]);
            state <= S_ADX_M;
          end
        end
        S_ADX_M: state <= S_ADX_U;
        S_ADX_U: begin
          adx   <= ema_res[22:0];
          state <= S_TRADE;
        end
        S_TRADE: begin
          if (adx > thresh && pos < lim_s) begin
            pos     <= pos + 17'sd1;
            cash    <= sat48(buy_sum);
            order_r <= ORD_BUY;
          end else if (adx < thresh && pos > -lim_s) begin
            pos     <= pos - 17'sd1;
            cash    <= sat48(sell_sum);
            order_r <= ORD_SELL;
          end
          state <= fin ? S_PNL_M : S_OUT;
        end
        S_PNL_M: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            order_code     <= order_r;
            position_now   <= pos;
            cash_now       <= cash;
            adx_now        <= adx;
            square_off_pnl <= pnl_val;
            if (fin) begin
              // end of run: back to priming
              prev_high  <= '0;
              prev_low   <= '0;
              prev_close <= '0;
              atr        <= '0;
              dip        <= '0;
              dim        <= '0;
              adx        <= '0;
              pos        <= '0;
              cash       <= '0;
              phase      <= '0;
            end else begin
              prev_high  <= h;
              prev_low   <= l;
              prev_close <= c;
              if (phase == 2'd0) begin
                phase <= 2'd1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // smoothed ADX stays within 0 to 100 percent
  a_adx_range: assert property (@(posedge clk) disable iff (rst) adx <= PCT_FULL)
    else $error("ADX above 100 percent");

  // a new result only ever comes from the output step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside output step");

  // no division is left running once the block is ready again
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !div_go)
    else $error("divider busy while idle");

endmodule
`default_nettype wire

// ===== tb/adx_threshold_trader_unit_tb.sv =====
// Self-checking testbench for the ADX threshold trader: directed and random bars.
`default_nettype none
module adx_threshold_trader_unit_tb;
  import adx_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] high_price = '0, low_price = '0, close_price = '0;
  logic final_bar = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] order_code;
  logic signed [16:0] position_now;
  logic signed [47:0] cash_now;
  logic [22:0] adx_now;
  logic signed [47:0] square_off_pnl;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_PERIOD;
  logic [22:0] cfg_data = '0;

  adx_threshold_trader_unit dut (.*);

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    order_t             dir;
    logic signed [16:0] pos;
    logic signed [47:0] cash;
    logic [22:0]        adx;
    logic signed [47:0] pnl;
  } bar_result_t;

  localparam logic signed [63:0] CASH_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] CASH_BOT = -CASH_TOP - 64'sd1;

  bar_result_t awaited_results[$];
  int errors = 0;
  int bars_sent = 0;
  int results_seen = 0;
  int trades_seen = 0;
  int finals_seen = 0;
  bit stall_hold = 1'b0;

  // Predictor copy of registers and trading state
  logic [10:0] m_period;
  logic [15:0] m_limit;
  logic [22:0] m_thresh;
  logic [63:0] m_alpha;
  logic [31:0] m_ph, m_pl, m_pc, m_atr, m_dip, m_dim, m_adx;
  int m_pos;
  logic signed [63:0] m_cash;
  logic [1:0] m_phase;

  function automatic logic [31:0] diff_abs(logic [31:0] a, logic [31:0] b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic logic signed [63:0] clamp_cash(logic signed [63:0] v);
    if (v > CASH_TOP) return CASH_TOP;
    if (v < CASH_BOT) return CASH_BOT;
    return v;
  endfunction

  function automatic logic [31:0] range_of(logic [31:0] h, logic [31:0] l, logic [31:0] rc);
    logic [31:0] tr, t2;
    tr = diff_abs(h, rc);
    t2 = diff_abs(l, rc);
    if (t2 > tr) tr = t2;
    if (h > l && h - l > tr) tr = h - l;
    return tr;
  endfunction

  function automatic logic [31:0] q16_ratio(logic [31:0] num, logic [31:0] den);
    logic [63:0] q;
    if (den == 0) return 0;
    q = {num, 16'h0} / {32'h0, den};
    return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] dir_index(logic [31:0] dp, logic [31:0] dm);
    logic [63:0] s, p;
    s = {32'h0, dp} + {32'h0, dm};
    if (s == 0) return 0;
    p = {32'h0, diff_abs(dp, dm)} * 64'd6553600;
    return 32'(p / s);
  endfunction

  function automatic logic [31:0] smooth(logic [31:0] old, logic [31:0] nv);
    logic [63:0] st;
    if (nv >= old) begin
      st = (m_alpha * {32'h0, nv - old} + 64'd32768) >> 16;
      return old + st[31:0];
    end
    st = (m_alpha * {32'h0, old - nv} + 64'd32768) >> 16;
    return old - st[31:0];
  endfunction

  function automatic void set_alpha();
    logic [63:0] n;
    n = m_period == 0 ? 64'd1 : {53'h0, m_period};
    m_alpha = (64'd131072 + (n + 1) / 2) / (n + 1);
  endfunction

  function automatic void clear_trading();
    m_ph = 0; m_pl = 0; m_pc = 0;
    m_atr = 0; m_dip = 0; m_dim = 0; m_adx = 0;
    m_pos = 0; m_cash = 0; m_phase = 0;
  endfunction

  // Work out the result of one bar and advance the predictor
  function automatic bar_result_t trade_bar(logic [31:0] h, logic [31:0] l,
                                            logic [31:0] c, logic fin);
    bar_result_t r;
    logic [31:0] dmp, dmm;
    int lim;
    r = '0;
    r.dir = ORD_NONE;
    if (m_phase != 0) begin
      dmp = h > m_ph ? h - m_ph : 32'h0;
      dmm = m_pl > l ? m_pl - l : 32'h0;
      lim = int'(m_limit);
      if (m_phase == 1) begin
        m_atr = range_of(h, l, c);
        m_dip = q16_ratio(dmp, m_atr);
        m_dim = q16_ratio(dmm, m_atr);
        m_adx = dir_index(m_dip, m_dim);
        m_phase = 2;
      end
      m_atr = smooth(m_atr, range_of(h, l, m_pc));
      m_dip = smooth(m_dip, q16_ratio(dmp, m_atr));
      m_dim = smooth(m_dim, q16_ratio(dmm, m_atr));
      m_adx = smooth(m_adx, dir_index(m_dip, m_dim));
      if (m_adx > {9'h0, m_thresh} && m_pos < lim) begin
        m_pos++;
        m_cash = clamp_cash(m_cash - $signed({32'h0, c}));
        r.dir = ORD_BUY;
      end else if (m_adx < {9'h0, m_thresh} && m_pos > -lim) begin
        m_pos--;
        m_cash = clamp_cash(m_cash + $signed({32'h0, c}));
        r.dir = ORD_SELL;
      end
    end else begin
      m_phase = 1;
    end
    m_ph = h; m_pl = l; m_pc = c;
    if (fin) r.pnl = 48'(clamp_cash(m_cash + $signed({32'h0, c}) * 64'(m_pos)));
    r.pos = 17'(m_pos);
    r.cash = 48'(m_cash);
    r.adx = m_adx[22:0];
    if (fin) clear_trading();
    return r;
  endfunction

  // Random gap: mostly short, sometimes long
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one bar; returns after acceptance, while the block is still busy
  task automatic send_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c, logic fin);
    int g;
    bar_result_t exp_r;
    g = gap_len();
    repeat (g) @(posedge clk);
    exp_r = trade_bar(h, l, c, fin);
    awaited_results.insert(awaited_results.size(), exp_r);
    in_valid <= 1'b1;
    high_price <= h;
    low_price <= l;
    close_price <= c;
    final_bar <= fin;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    bars_sent++;
    @(posedge clk);
  endtask

  // Wait for every result, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    while (awaited_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [22:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PERIOD: begin
        m_period = val[10:0];
        set_alpha();
      end
      REG_LIMIT: m_limit = val[15:0];
      REG_THRESH: m_thresh = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver stall, held off at times
  always @(posedge clk) begin
    if (rst || stall_hold) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 4) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 99) < 30) out_stall <= 1'b0;
  end

  function automatic bit final_bar_seen(bar_result_t e);
    return e.pnl != 0;
  endfunction

  // Result checker
  always @(posedge clk) begin
    bar_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result, no bar outstanding");
      end else begin
        e = awaited_results.pop_front();
        if (order_code != e.dir || position_now != e.pos || cash_now != e.cash ||
            adx_now != e.adx || square_off_pnl != e.pnl) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: result %0d exp dir=%0d pos=%0d cash=%0d adx=%0d pnl=%0d",
                     results_seen, e.dir, e.pos, e.cash, e.adx, e.pnl);
            $display("       got dir=%0d pos=%0d cash=%0d adx=%0d pnl=%0d",
                     order_code, position_now, cash_now, adx_now, square_off_pnl);
          end
        end
        if (e.dir != ORD_NONE) trades_seen++;
        if (final_bar_seen(e)) finals_seen++;
      end
    end
  end

  // Price around a base with a random swing
  function automatic logic [31:0] near(logic [31:0] base, int span);
    int d;
    d = $urandom_range(0, 2 * span) - span;
    return base + 32'(d);
  endfunction

  // Directed: extremes, seeding, zero divisors, low above high, saturation
  task automatic test_directed();
    send_bar(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1'b0);
    send_bar(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'h0, 32'h0, 32'h0, 1'b0);
    send_bar(32'h0, 32'h0, 32'h0, 1'b0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // flat run: zero divisors throughout
    send_bar(32'h10000, 32'h10000, 32'h10000, 1'b0);
    send_bar(32'h10000, 32'h10000, 32'h10000, 1'b0);
    send_bar(32'h10000, 32'h10000, 32'h10000, 1'b1);
    // single-bar run
    send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b1);
    // strong trend up then down
    for (int i = 0; i < 8; i++)
      send_bar(32'h100000 + i * 32'h40000, 32'h0F0000 + i * 32'h40000,
               32'h0F8000 + i * 32'h40000, 1'b0);
    for (int i = 0; i < 6; i++)
      send_bar(32'h300000 - i * 32'h40000, 32'h2F0000 - i * 32'h40000,
               32'h2F8000 - i * 32'h40000, i == 5);
  endtask

  // Register settings at the extremes, with cash pushed toward saturation
  task automatic test_extremes();
    write_reg(REG_PERIOD, 23'd0);
    write_reg(REG_LIMIT, 23'd65535);
    write_reg(REG_THRESH, 23'd0);
    for (int i = 0; i < 12; i++)
      send_bar(32'hFFFF_FFF0 - i * 7, 32'h0000_0010 + i, 32'hFFFF_FFFF - i, i == 11);
    drain();
    write_reg(REG_THRESH, 23'd6553600);
    for (int i = 0; i < 12; i++)
      send_bar($urandom, $urandom, $urandom, i == 11);
    drain();
    write_reg(REG_THRESH, 23'h7FFFFF);
    write_reg(REG_PERIOD, 23'h7FF);
    write_reg(REG_LIMIT, 23'd0);
    for (int i = 0; i < 8; i++)
      send_bar($urandom, $urandom, $urandom, i == 7);
    drain();
  endtask

  // Random runs: mostly plausible bars, some wild ones
  task automatic test_random(int total);
    int sent, runlen;
    logic [31:0] base, h, l, c;
    sent = 0;
    while (sent < total) begin
      drain();
      case ($urandom_range(0, 4))
        0: write_reg(REG_PERIOD, 23'($urandom_range(1, 4)));
        1: write_reg(REG_PERIOD, 23'($urandom_range(5, 30)));
        2: write_reg(REG_PERIOD, 23'($urandom_range(0, 2047)));
        3: write_reg(REG_LIMIT, 23'($urandom_range(0, 5)));
        default: write_reg(REG_THRESH, 23'($urandom_range(0, 6553600)));
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(REG_LIMIT, 23'($urandom_range(0, 65535)));
      stall_hold = ($urandom_range(0, 3) == 0);
      runlen = $urandom_range(1, 60);
      base = $urandom_range(32'h10000, 32'h7FFF_FFFF);
      for (int i = 0; i < runlen && sent < total; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          h = $urandom; l = $urandom; c = $urandom;
        end else begin
          base = near(base, 32'h40000);
          h = base + $urandom_range(0, 32'h30000);
          l = base - $urandom_range(0, 32'h30000);
          c = $urandom_range(l, h);
        end
        send_bar(h, l, c, i == runlen - 1 || $urandom_range(0, 99) == 0);
        sent++;
      end
    end
    stall_hold = 1'b0;
  endtask

  initial begin
    m_period = 11'd14;
    m_limit = 16'd1;
    m_thresh = 23'd1638400;
    set_alpha();
    clear_trading();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_extremes();
    test_random(895);
    drain();
    $display("Covered %0d bars and %0d results: %0d orders, %0d nonzero square-offs,",
             bars_sent, results_seen, trades_seen, finals_seen);
    $display("across period, limit and threshold extremes with random gaps and stalls.");
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d, results still outstanding: %0d", errors,
               awaited_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

  // Overall time limit
  initial begin
    #20000000;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/adx_pkg.sv
src/adx_div.sv
src/adx_mul.sv
src/adx_threshold_trader_unit.sv
tb/adx_threshold_trader_unit_tb.sv
